[hdl/pstl_pkg.sv]
package pstl_pkg;

   localparam int PID_W            = 13;
   localparam int POS_W            = 6;
   localparam int SLOT_OUT_W       = 6;
   localparam int ENTRIES_W        = 7;
   localparam int DEFAULT_CAPACITY = 64;

   localparam logic [PID_W-1:0] PID_ZERO      = 13'h0000;
   localparam logic [PID_W-1:0] PID_BASE_INFO = 13'h1FFB;
   localparam logic [PID_W-1:0] PID_NULL      = 13'h1FFF;

   typedef enum logic {
      OP_GET  = 1'b0,
      OP_NEXT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      SPECIAL_NONE = 2'd0,
      SPECIAL_ZERO = 2'd1,
      SPECIAL_BASE = 2'd2,
      SPECIAL_NULL = 2'd3
   } special_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_COMMIT = 1'b1
   } state_type;

   // compare flags a cell keeps for the request in flight
   typedef struct packed {
      logic valid;
      logic lt;
      logic eq;
      logic sel;
   } cell_flags_type;

endpackage

[hdl/pstl_cell.sv]
module pstl_cell #(
   parameter int INDEX  = 0,
   parameter int SLOT_W = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        capture,
   input  logic [pstl_pkg::PID_W-1:0]  req_pid,
   input  logic [pstl_pkg::POS_W-1:0]  req_position,
   input  logic                        insert,
   input  logic [pstl_pkg::PID_W-1:0]  ins_pid,
   input  logic [SLOT_W-1:0]           ins_slot,
   input  pstl_pkg::cell_flags_type    prev_flags,
   input  logic [pstl_pkg::PID_W-1:0]  prev_pid,
   input  logic [SLOT_W-1:0]           prev_slot,
   output pstl_pkg::cell_flags_type    flags,
   output logic [pstl_pkg::PID_W-1:0]  cell_pid,
   output logic [SLOT_W-1:0]           cell_slot
);

   localparam logic HAS_POS = INDEX < (1 << pstl_pkg::POS_W);

   logic                       valid_ff, valid_in;
   logic                       lt_ff, eq_ff, sel_ff;
   logic [pstl_pkg::PID_W-1:0] pid_ff, pid_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;

   always_comb begin
      valid_in = valid_ff;
      pid_in   = pid_ff;
      slot_in  = slot_ff;
      if (insert && !lt_ff) begin
         if (INDEX == 0 || prev_flags.lt) begin
            valid_in = 1'b1;
            pid_in   = ins_pid;
            slot_in  = ins_slot;
         end else begin
            valid_in = prev_flags.valid;
            pid_in   = prev_pid;
            slot_in  = prev_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (capture) begin
            lt_ff  <= valid_ff && (pid_ff < req_pid);
            eq_ff  <= valid_ff && (pid_ff == req_pid);
            sel_ff <= HAS_POS && valid_ff &&
                      (req_position == pstl_pkg::POS_W'(INDEX));
         end
      end
   end

   always_ff @(posedge clock) begin
      pid_ff  <= pid_in;
      slot_ff <= slot_in;
   end

   assign flags.valid = valid_ff;
   assign flags.lt    = lt_ff;
   assign flags.eq    = eq_ff;
   assign flags.sel   = sel_ff;
   assign cell_pid    = pid_ff;
   assign cell_slot   = slot_ff;

endmodule

[hdl/pid_sorted_table_lookup_insert.sv]
// Sorted packet identifier table held in a row of CAPACITY cells, kept in
// ascending order, each entry tied to a slot number given in creation order.
// In the accept cycle every cell registers a compare of its entry with the
// request identifier and position. Once the response register is free, the
// commit state selects the hit or read entry and, on a miss with room, shifts
// the cells at and above the sorted position up one place while the new entry
// drops in. The next request is taken once the commit writes the response.
module pid_sorted_table_lookup_insert #(
   parameter int CAPACITY = pstl_pkg::DEFAULT_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [pstl_pkg::PID_W-1:0]        req_pid,
   input  logic [pstl_pkg::POS_W-1:0]        req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_special,
   output logic [pstl_pkg::SLOT_OUT_W-1:0]   rsp_slot,
   output logic [pstl_pkg::PID_W-1:0]        rsp_entry_pid,
   output logic                              rsp_created,
   output logic                              rsp_valid_res,
   output logic                              rsp_full_res,
   output logic [pstl_pkg::ENTRIES_W-1:0]    rsp_entries
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   pstl_pkg::state_type state_ff, state_in;
   logic                       accept, out_free, commit, insert;
   pstl_pkg::op_type           op_ff;
   logic [pstl_pkg::PID_W-1:0] pid_ff;
   logic [CNT_W-1:0]           count_ff, count_in;

   pstl_pkg::cell_flags_type   flags [CAPACITY];
   logic [pstl_pkg::PID_W-1:0] cell_pid [CAPACITY];
   logic [SLOT_W-1:0]          cell_slot [CAPACITY];
   logic [CAPACITY-1:0]        eq_vec, valid_vec;

   logic                       hit, sel_any;
   logic [SLOT_W-1:0]          hit_slot, sel_slot;
   logic [pstl_pkg::PID_W-1:0] sel_pid;
   pstl_pkg::special_type      special;

   logic                            rsp_valid_ff;
   pstl_pkg::special_type           rsp_special_ff, rsp_special_in;
   logic [SLOT_W-1:0]               rsp_slot_ff, rsp_slot_in;
   logic [pstl_pkg::PID_W-1:0]      rsp_pid_ff, rsp_pid_in;
   logic                            rsp_created_ff, rsp_created_in;
   logic                            rsp_vres_ff, rsp_vres_in;
   logic                            rsp_full_ff, rsp_full_in;
   logic [CNT_W-1:0]                rsp_count_ff;

   assign req_ready = (state_ff == pstl_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == pstl_pkg::ST_COMMIT) && out_free;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         pstl_pkg::cell_flags_type   prev_flags;
         logic [pstl_pkg::PID_W-1:0] prev_pid;
         logic [SLOT_W-1:0]          prev_slot;
         if (gi == 0) begin : g_first
            assign prev_flags = '0;
            assign prev_pid   = '0;
            assign prev_slot  = '0;
         end else begin : g_rest
            assign prev_flags = flags[gi-1];
            assign prev_pid   = cell_pid[gi-1];
            assign prev_slot  = cell_slot[gi-1];
         end
         pstl_cell #(
            .INDEX  (gi),
            .SLOT_W (SLOT_W)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .capture      (accept),
            .req_pid      (req_pid),
            .req_position (req_position),
            .insert       (insert),
            .ins_pid      (pid_ff),
            .ins_slot     (SLOT_W'(count_ff)),
            .prev_flags   (prev_flags),
            .prev_pid     (prev_pid),
            .prev_slot    (prev_slot),
            .flags        (flags[gi]),
            .cell_pid     (cell_pid[gi]),
            .cell_slot    (cell_slot[gi])
         );
         assign eq_vec[gi]    = flags[gi].eq;
         assign valid_vec[gi] = flags[gi].valid;
      end
   endgenerate

   // at most one cell matches, so the selects are plain and-or
   always_comb begin
      hit      = 1'b0;
      sel_any  = 1'b0;
      hit_slot = '0;
      sel_slot = '0;
      sel_pid  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit      = hit | flags[i].eq;
         sel_any  = sel_any | flags[i].sel;
         hit_slot = hit_slot | (cell_slot[i] & {SLOT_W{flags[i].eq}});
         sel_slot = sel_slot | (cell_slot[i] & {SLOT_W{flags[i].sel}});
         sel_pid  = sel_pid | (cell_pid[i] & {pstl_pkg::PID_W{flags[i].sel}});
      end
   end

   always_comb begin
      case (pid_ff)
         pstl_pkg::PID_ZERO:      special = pstl_pkg::SPECIAL_ZERO;
         pstl_pkg::PID_BASE_INFO: special = pstl_pkg::SPECIAL_BASE;
         pstl_pkg::PID_NULL:      special = pstl_pkg::SPECIAL_NULL;
         default:                 special = pstl_pkg::SPECIAL_NONE;
      endcase
   end

   assign insert = commit && (op_ff == pstl_pkg::OP_GET) &&
                   (special == pstl_pkg::SPECIAL_NONE) && !hit &&
                   (count_ff < CNT_W'(CAPACITY));
   assign count_in = insert ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pstl_pkg::ST_IDLE:   if (accept) state_in = pstl_pkg::ST_COMMIT;
         pstl_pkg::ST_COMMIT: if (out_free) state_in = pstl_pkg::ST_IDLE;
         default:             state_in = pstl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_special_in = pstl_pkg::SPECIAL_NONE;
      rsp_slot_in    = '0;
      rsp_pid_in     = pid_ff;
      rsp_created_in = 1'b0;
      rsp_vres_in    = 1'b1;
      rsp_full_in    = 1'b0;
      if (op_ff == pstl_pkg::OP_NEXT) begin
         rsp_vres_in = sel_any;
         rsp_slot_in = sel_slot;
         rsp_pid_in  = sel_pid;
      end else if (special != pstl_pkg::SPECIAL_NONE) begin
         rsp_special_in = special;
      end else if (hit) begin
         rsp_slot_in = hit_slot;
      end else if (insert) begin
         rsp_slot_in    = SLOT_W'(count_ff);
         rsp_created_in = 1'b1;
      end else begin
         rsp_vres_in = 1'b0;
         rsp_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pstl_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= pstl_pkg::op_type'(req_operation);
         pid_ff <= req_pid;
      end
      if (commit) begin
         rsp_special_ff <= rsp_special_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_pid_ff     <= rsp_pid_in;
         rsp_created_ff <= rsp_created_in;
         rsp_vres_ff    <= rsp_vres_in;
         rsp_full_ff    <= rsp_full_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_special   = rsp_special_ff;
   assign rsp_slot      = pstl_pkg::SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_entry_pid = rsp_pid_ff;
   assign rsp_created   = rsp_created_ff;
   assign rsp_valid_res = rsp_vres_ff;
   assign rsp_full_res  = rsp_full_ff;
   assign rsp_entries   = pstl_pkg::ENTRIES_W'(rsp_count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_cells_match_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("occupied cells disagree with entry count");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == pstl_pkg::ST_COMMIT |-> $onehot0(eq_vec))
      else $error("identifier held in more than one cell");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the table");

   a_created_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_created |-> rsp_valid_res && !rsp_full_res)
      else $error("created response with bad flags");
`endif

endmodule
